FILE: hdl/cmps_pkg.sv
// Shared types and constants for the Coulomb pair-sum block.
package cmps_pkg;

  localparam int MaxRefs = 16;
  localparam int RefIdxW = $clog2(MaxRefs);
  localparam int RefCntW = $clog2(MaxRefs + 1);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_PROBE  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [15:0] MinDistRst = 16'd655;
  localparam logic [1:0]  RegMinDist = 2'd0;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DIFF  = 11'b00000000010,
    S_SQX   = 11'b00000000100,
    S_SQY   = 11'b00000001000,
    S_SQZ   = 11'b00000010000,
    S_SQRT  = 11'b00000100000,
    S_PROD  = 11'b00001000000,
    S_DIV   = 11'b00010000000,
    S_ACC   = 11'b00100000000,
    S_NEXT  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

endpackage

FILE: hdl/coulomb_monopole_pair_sum.sv
// Top level: reference store, pair sequencer, shared root and divide units.
// A clear or load is handled in the idle state. A probe walks the stored references one at
// a time; each pair passes through a reference read, the coordinate
// differences, three squares on one shared 33x33 multiplier, a 34-step
// bit-serial square root, the charge product, a 64-step restoring divide and
// the accumulate and advance steps. A pair skipped for being too close
// leaves out the root, product, divide and accumulate steps.
// A result is held in an output register until taken, the next word waits.
module coulomb_monopole_pair_sum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[1:0], pos_x[33:2], pos_y[65:34], pos_z[97:66], charge[129:98], zero fill
  input  logic [135:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // interaction[63:0], skipped_pairs[79:64], status[81:80], zero fill
  output logic [87:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import cmps_pkg::*;

  state_t state_r;
  logic [15:0] min_dist_r;
  logic [31:0] ref_x_r [MaxRefs];
  logic [31:0] ref_y_r [MaxRefs];
  logic [31:0] ref_z_r [MaxRefs];
  logic [31:0] ref_q_r [MaxRefs];
  logic [31:0] rd_x_r, rd_y_r, rd_z_r, rd_q_r;
  logic [RefCntW-1:0] ref_cnt_r;
  logic [RefIdxW-1:0] idx_r;
  logic signed [63:0] sum_r;
  logic [15:0] skip_r;
  logic [1:0]  flags_r;
  logic [31:0] px_r, py_r, pz_r, pq_r;
  logic        last_r;
  logic [32:0] mx_r, my_r, mz_r;
  logic [67:0] d2_r;
  logic [33:0] root_r;
  logic [67:0] rem_r;
  logic [5:0]  cnt_r;
  logic [63:0] mag_r, quo_r;
  logic        neg_r;
  logic [63:0] out_int_r;
  logic [15:0] out_skip_r;
  logic [1:0]  out_st_r;
  logic        out_v_r;

  logic [1:0]  in_op;
  logic        in_acc, cfg_wr;
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic [33:0] try_root;
  logic [67:0] try_sq;
  logic [63:0] div_rem_sh;
  logic [63:0] thr;
  logic signed [64:0] sum_ext;
  logic signed [63:0] term;

  assign in_op      = in_tdata[1:0];
  assign in_tready  = (state_r == S_IDLE) && !out_v_r;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == RegMinDist[0]) ? {16'd0, min_dist_r} : 32'd0;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_st_r, out_skip_r, out_int_r};
  assign thr        = 64'(min_dist_r) * 64'(min_dist_r);

  always_comb begin
    mul_a = mx_r;
    mul_b = mx_r;
    case (state_r)
      S_SQY:   begin mul_a = my_r; mul_b = my_r; end
      S_SQZ:   begin mul_a = mz_r; mul_b = mz_r; end
      S_SQRT:  begin mul_a = 33'(try_root); mul_b = 33'(try_root); end
      S_PROD:  begin
        mul_a = {1'b0, pq_r[31] ? -pq_r : pq_r};
        mul_b = {1'b0, rd_q_r[31] ? -rd_q_r : rd_q_r};
      end
      default: ;
    endcase
  end
  assign try_root = root_r | (34'd1 << cnt_r);
  // the root stays below 2^33, so a trial with the top bit set squares to 2^66
  assign mul_p    = mul_a * mul_b;
  assign try_sq   = try_root[33] ? 68'h4_0000_0000_0000_0000 : 68'(mul_p);
  assign div_rem_sh = {rem_r[62:0], mag_r[63]};
  assign term     = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign sum_ext  = 65'(sum_r) + 65'(term);

  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_LOAD && ref_cnt_r < RefCntW'(MaxRefs)) begin
      ref_x_r[ref_cnt_r[RefIdxW-1:0]] <= in_tdata[33:2];
      ref_y_r[ref_cnt_r[RefIdxW-1:0]] <= in_tdata[65:34];
      ref_z_r[ref_cnt_r[RefIdxW-1:0]] <= in_tdata[97:66];
      ref_q_r[ref_cnt_r[RefIdxW-1:0]] <= in_tdata[129:98];
    end
    rd_x_r <= ref_x_r[idx_r];
    rd_y_r <= ref_y_r[idx_r];
    rd_z_r <= ref_z_r[idx_r];
    rd_q_r <= ref_q_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      min_dist_r <= MinDistRst;
      ref_cnt_r  <= '0;
      idx_r      <= '0;
      sum_r      <= '0;
      skip_r     <= '0;
      flags_r    <= '0;
      out_v_r    <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cfg_wr && cfg_paddr[2] == RegMinDist[0]) min_dist_r <= cfg_pwdata[15:0];
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            px_r <= in_tdata[33:2];
            py_r <= in_tdata[65:34];
            pz_r <= in_tdata[97:66];
            pq_r <= in_tdata[129:98];
            last_r <= in_tlast;
            idx_r <= '0;
            case (in_op)
              OP_CLEAR: begin
                ref_cnt_r <= '0; sum_r <= '0; skip_r <= '0; flags_r <= '0;
              end
              OP_LOAD: begin
                if (ref_cnt_r < RefCntW'(MaxRefs)) ref_cnt_r <= ref_cnt_r + 1'b1;
                else flags_r[0] <= 1'b1;
              end
              OP_PROBE: state_r <= (ref_cnt_r == '0) ? S_NEXT : S_OUT;
              default: ;
            endcase
          end
        end
        S_DIFF: begin
          mx_r <= ($signed({px_r[31], px_r}) >= $signed({rd_x_r[31], rd_x_r}))
                  ? {px_r[31], px_r} - {rd_x_r[31], rd_x_r}
                  : {rd_x_r[31], rd_x_r} - {px_r[31], px_r};
          my_r <= ($signed({py_r[31], py_r}) >= $signed({rd_y_r[31], rd_y_r}))
                  ? {py_r[31], py_r} - {rd_y_r[31], rd_y_r}
                  : {rd_y_r[31], rd_y_r} - {py_r[31], py_r};
          mz_r <= ($signed({pz_r[31], pz_r}) >= $signed({rd_z_r[31], rd_z_r}))
                  ? {pz_r[31], pz_r} - {rd_z_r[31], rd_z_r}
                  : {rd_z_r[31], rd_z_r} - {pz_r[31], pz_r};
          state_r <= S_SQX;
        end
        S_SQX: begin d2_r <= 68'(mul_p); state_r <= S_SQY; end
        S_SQY: begin d2_r <= d2_r + 68'(mul_p); state_r <= S_SQZ; end
        S_SQZ: begin
          d2_r <= d2_r + 68'(mul_p);
          root_r <= '0;
          cnt_r <= 6'd33;
          if ((d2_r + 68'(mul_p)) < 68'(thr) || (d2_r + 68'(mul_p)) == '0) begin
            if (skip_r != 16'hFFFF) skip_r <= skip_r + 1'b1;
            state_r <= S_NEXT;
          end else begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (try_sq <= d2_r) root_r <= try_root;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= S_PROD;
        end
        S_PROD: begin
          if (root_r == '0) begin
            if (skip_r != 16'hFFFF) skip_r <= skip_r + 1'b1;
            state_r <= S_NEXT;
          end else begin
            mag_r <= mul_p[63:0];
            neg_r <= pq_r[31] ^ rd_q_r[31];
            rem_r <= '0;
            cnt_r <= 6'd63;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          mag_r <= {mag_r[62:0], 1'b0};
          if (68'(div_rem_sh) >= 68'(root_r)) begin
            rem_r <= 68'(div_rem_sh) - 68'(root_r);
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= 68'(div_rem_sh);
            quo_r <= {quo_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= S_ACC;
        end
        S_ACC: begin
          if (sum_ext[64] != sum_ext[63]) begin
            sum_r <= sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            flags_r[1] <= 1'b1;
          end else begin
            sum_r <= sum_ext[63:0];
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (ref_cnt_r != '0 && RefCntW'(idx_r) != ref_cnt_r - 1'b1) begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_OUT;
          end else if (last_r) begin
            out_int_r  <= sum_r;
            out_skip_r <= skip_r;
            out_st_r   <= flags_r[1] ? ST_SAT : (flags_r[0] ? ST_DROP : ST_OK);
            out_v_r    <= 1'b1;
            sum_r <= '0; skip_r <= '0; flags_r <= '0;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_IDLE;
          end
        end
        // wait here while the next reference is read into the rd registers
        S_OUT: state_r <= S_DIFF;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ref_cnt_r <= RefCntW'(MaxRefs)) else $error("reference count overflow");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r && $stable(out_int_r))
    else $error("result dropped");
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROD |-> root_r <= 34'h2_0000_0000) else $error("root too big");
`endif

endmodule
